>>> rtl/core/sha_pkg.sv
// ============================================================================
// sha_pkg
// Shared types, constants and bit functions for the SHA-256 byte hasher.
// ============================================================================
package sha_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ROUNDS   = 64;
    localparam int unsigned WIN_D    = 16;
    localparam int unsigned DIG_W    = 8;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [2:0] IDX_LAST  = 3'd7;
    localparam logic [5:0] RND_LAST  = 6'd63;

    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TABLE [DIG_W] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FIN,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_OUT
    } t_state;

    // what follows a compression
    typedef enum logic [1:0] {
        PH_DATA,
        PH_PADBLK,
        PH_FINAL
    } t_phase;

    typedef struct packed {
        logic       absorb;   // shift one byte into the word accumulator
        logic       push;     // accumulator word complete, shift into window
        logic       step;     // schedule step for one round
        logic [7:0] data;
    } t_sched_ctrl;

    typedef struct packed {
        logic load;     // working words <= chaining words
        logic step;     // one compression round
        logic fin;      // chaining words += working words
        logic restart;  // chaining words <= initial value
    } t_core_ctrl;

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
        ror = (v >> s) | (v << (WORD_W - s));
    endfunction

endpackage

>>> rtl/core/sha_sched.sv
// ============================================================================
// sha_sched
// Byte packer and 16-word message schedule shift line.
// ============================================================================
module sha_sched (
    input  logic                 i_clk,
    input  sha_pkg::t_sched_ctrl i_ctrl,
    output logic [31:0]          o_w
);
    import sha_pkg::*;

    logic [23:0] r_acc;
    logic [31:0] r_win [WIN_D];
    logic [31:0] s0, s1, w_next;

    // window holds W[t] .. W[t+15]; produce W[t+16]
    always_comb begin
        s0     = ror(r_win[1], 7) ^ ror(r_win[1], 18) ^ (r_win[1] >> 3);
        s1     = ror(r_win[14], 17) ^ ror(r_win[14], 19) ^ (r_win[14] >> 10);
        w_next = r_win[0] + s0 + r_win[9] + s1;
    end

    assign o_w = r_win[0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.absorb) begin
            r_acc <= {r_acc[15:0], i_ctrl.data};
        end
        if (i_ctrl.push || i_ctrl.step) begin
            for (int i = 0; i < WIN_D - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[WIN_D - 1] <= i_ctrl.push ? {r_acc, i_ctrl.data} : w_next;
        end
    end

endmodule

>>> rtl/core/sha_round.sv
// ============================================================================
// sha_round
// Compression round unit with working words and chaining state.
// ============================================================================
module sha_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha_pkg::t_core_ctrl i_ctrl,
    input  logic [31:0]         i_k,
    input  logic [31:0]         i_w,
    input  logic [2:0]          i_sel,
    output logic [31:0]         o_word
);
    import sha_pkg::*;

    logic [31:0] r_work  [DIG_W];
    logic [31:0] r_chain [DIG_W];
    logic [31:0] big0, big1, ch, maj, t1;

    always_comb begin
        big1 = ror(r_work[4], 6) ^ ror(r_work[4], 11) ^ ror(r_work[4], 25);
        ch   = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
        t1   = r_work[7] + big1 + ch + i_k + i_w;
        big0 = ror(r_work[0], 2) ^ ror(r_work[0], 13) ^ ror(r_work[0], 22);
        maj  = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^
               (r_work[1] & r_work[2]);
    end

    assign o_word = r_chain[i_sel];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            for (int i = 0; i < DIG_W; i++) begin
                r_work[i] <= r_chain[i];
            end
        end else if (i_ctrl.step) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= t1 + big0 + maj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.restart) begin
            for (int i = 0; i < DIG_W; i++) begin
                r_chain[i] <= IV_TABLE[i];
            end
        end else if (i_ctrl.fin) begin
            for (int i = 0; i < DIG_W; i++) begin
                r_chain[i] <= r_chain[i] + r_work[i];
            end
        end
    end

endmodule

>>> rtl/core/sha256_byte_stream_hasher.sv
// ============================================================================
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, one optional byte per transfer, digest out as
// eight 32-bit words.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  input   | in        | i_valid / o_stall  | i_data_byte, i_has_byte,
//          |           |                    | i_end_of_message
//  digest  | out       | o_valid / i_stall  | o_digest_word, o_word_index,
//          |           |                    | o_last_word
//
//  Flow: a byte that does not complete a block leaves the block idle. A byte
//  that fills the 64-byte block starts a compression (load, 64 rounds,
//  chaining add), run by the single round unit doing one round per cycle.
//  End of message: padding goes in one byte per cycle up to the 64th byte,
//  with an idle ST_ZERO step ahead of the eight length bytes, then a
//  compression (twice when the length spills into an extra block), then
//  eight digest transfers, each held while i_stall is high.
//  o_stall is high whenever the block is not idle.
//  Reset: synchronous active low; clears the sequencer, counters and loads
//  the initial chaining value. A stalled digest word holds until taken.
//
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [5:0]  r_fill, n_fill;        // bytes in the current block
    logic [54:0] r_blocks, n_blocks;    // completed data blocks (bit count / 512)
    logic [63:0] r_len, n_len;          // length field, shifted out MSB first
    logic        r_pending, n_pending;  // end mark seen on a block-completing byte
    logic        r_extra, n_extra;      // length needs an extra block
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_idx, n_idx;

    logic        in_fire, out_fire, fill_full;
    logic        absorb;
    logic [7:0]  absorb_data;
    t_sched_ctrl sched_ctrl;
    t_core_ctrl  core_ctrl;
    logic [31:0] w_cur;

    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = (r_state == ST_OUT);
    assign in_fire   = i_valid && !o_stall;
    assign out_fire  = o_valid && !i_stall;
    assign fill_full = (r_fill == FILL_LAST);

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    priority if (i_has_byte && fill_full) n_state = ST_LOAD;
                    else if (i_end_of_message)            n_state = ST_PAD;
                    else                                  n_state = ST_IDLE;
                end
            end
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: if (r_round == RND_LAST) n_state = ST_FIN;
            ST_FIN: begin
                unique case (r_phase)
                    PH_DATA:   n_state = r_pending ? ST_PAD : ST_IDLE;
                    PH_PADBLK: n_state = ST_ZERO;
                    PH_FINAL:  n_state = ST_OUT;
                    default:   n_state = ST_IDLE;
                endcase
            end
            ST_PAD: n_state = fill_full ? ST_LOAD : ST_ZERO;
            ST_ZERO: begin
                priority if (r_extra)          n_state = fill_full ? ST_LOAD : ST_ZERO;
                else if (r_fill == LEN_POS)    n_state = ST_LEN;
                else                           n_state = ST_ZERO;
            end
            ST_LEN: if (fill_full) n_state = ST_LOAD;
            ST_OUT: if (out_fire && r_idx == IDX_LAST) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------ datapath and counters
    always_comb begin
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_blocks    = r_blocks;
        n_len       = r_len;
        n_pending   = r_pending;
        n_extra     = r_extra;
        n_round     = r_round;
        n_idx       = r_idx;
        absorb      = 1'b0;
        absorb_data = '0;
        core_ctrl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && i_has_byte) begin
                    absorb      = 1'b1;
                    absorb_data = i_data_byte;
                    n_fill      = r_fill + 6'd1;
                    if (fill_full) begin
                        n_blocks  = r_blocks + 55'd1;
                        n_phase   = PH_DATA;
                        n_pending = i_end_of_message;
                    end
                end
            end
            ST_LOAD: begin
                core_ctrl.load = 1'b1;
                n_round        = '0;
            end
            ST_ROUND: begin
                core_ctrl.step = 1'b1;
                n_round        = r_round + 6'd1;
            end
            ST_FIN: begin
                core_ctrl.fin = 1'b1;
            end
            ST_PAD: begin
                // length = completed blocks * 512 + bytes held * 8
                n_len       = {r_blocks, r_fill, 3'b000};
                n_pending   = 1'b0;
                absorb      = 1'b1;
                absorb_data = PAD_BYTE;
                n_fill      = r_fill + 6'd1;
                if (fill_full) begin
                    n_phase = PH_PADBLK;
                    n_extra = 1'b0;
                end else begin
                    n_extra = (r_fill >= LEN_POS);
                end
            end
            ST_ZERO: begin
                if (r_extra || r_fill != LEN_POS) begin
                    absorb = 1'b1;
                    n_fill = r_fill + 6'd1;
                    if (r_extra && fill_full) begin
                        n_phase = PH_PADBLK;
                        n_extra = 1'b0;
                    end
                end
            end
            ST_LEN: begin
                absorb      = 1'b1;
                absorb_data = r_len[63:56];
                n_len       = {r_len[55:0], 8'h00};
                n_fill      = r_fill + 6'd1;
                if (fill_full) n_phase = PH_FINAL;
            end
            ST_OUT: begin
                if (out_fire) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == IDX_LAST) begin
                        core_ctrl.restart = 1'b1;
                        n_fill            = '0;
                        n_blocks          = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sched_ctrl.absorb = absorb;
        sched_ctrl.push   = absorb && (r_fill[1:0] == 2'b11);
        sched_ctrl.step   = (r_state == ST_ROUND);
        sched_ctrl.data   = absorb_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_DATA;
            r_fill    <= '0;
            r_blocks  <= '0;
            r_pending <= 1'b0;
            r_extra   <= 1'b0;
            r_round   <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_fill    <= n_fill;
            r_blocks  <= n_blocks;
            r_pending <= n_pending;
            r_extra   <= n_extra;
            r_round   <= n_round;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    sha_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (sched_ctrl),
        .o_w    (w_cur)
    );

    sha_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (core_ctrl),
        .i_k     (K_TABLE[r_round]),
        .i_w     (w_cur),
        .i_sel   (r_idx),
        .o_word  (o_digest_word)
    );

    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == IDX_LAST);

    // ---------------------------------------------------------------- checks
    // every compression starts on an empty block
    a_load_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_fill == '0))
        else $error("compression started with a partly filled block");

    // 64 rounds then the chaining add
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == RND_LAST) |=> (r_state == ST_FIN))
        else $error("round sequence did not end in the chaining add");

    // input is held off while the digest goes out
    a_no_input_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input ready during digest output");

    // a digest burst always starts at word 0
    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_word_index == '0))
        else $error("digest burst did not start at word 0");

endmodule
